// File: hw/rtl/ngrp_pkg.sv
// Package for the NMEA GGA/RMC field parser: character codes, header
// strings, result codes and field numbers shared by the RTL files.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ngrp_pkg;

  localparam int BYTE_W  = 8;
  localparam int KIND_W  = 2;
  localparam int FIX_W   = 2;
  localparam int DATE_W  = 48;
  localparam int TIME_W  = 48;
  localparam int LATW_W  = 32;
  localparam int LATF_W  = 40;
  localparam int LONW_W  = 40;
  localparam int LONF_W  = 40;
  localparam int HDR_LEN = 6;

  localparam logic [7:0] NEWLINE = 8'h0A;
  localparam logic [7:0] COMMA   = 8'h2C;
  localparam logic [7:0] CHAR_1  = 8'h31;
  localparam logic [7:0] CHAR_2  = 8'h32;

  localparam logic [47:0] HDR_RMC = "$GPRMC";
  localparam logic [47:0] HDR_GGA = "$GPGGA";

  localparam logic [1:0] KIND_OTHER = 2'd0;
  localparam logic [1:0] KIND_RMC   = 2'd1;
  localparam logic [1:0] KIND_GGA   = 2'd2;

  localparam logic [1:0] FIX_NONE = 2'd0;
  localparam logic [1:0] FIX_GPS  = 2'd1;
  localparam logic [1:0] FIX_DGPS = 2'd2;

  // field numbers (comma count while inside the field)
  localparam logic [7:0] FLD_TIME = 8'd1;
  localparam logic [7:0] FLD_LAT  = 8'd2;
  localparam logic [7:0] FLD_NS   = 8'd3;
  localparam logic [7:0] FLD_LON  = 8'd4;
  localparam logic [7:0] FLD_EW   = 8'd5;
  localparam logic [7:0] FLD_FIX  = 8'd6;
  localparam logic [7:0] FLD_DATE = 8'd9;

  // bits of the field-present vector
  localparam int PF_TIME = 0;
  localparam int PF_LAT  = 1;
  localparam int PF_NS   = 2;
  localparam int PF_LON  = 3;
  localparam int PF_EW   = 4;
  localparam int PF_FIX  = 5;
  localparam int PF_DATE = 6;
  localparam int PF_W    = 7;

  function automatic logic [7:0] hdr_char(input logic [47:0] hdr, input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = hdr[47:40];
      3'd1:    ch = hdr[39:32];
      3'd2:    ch = hdr[31:24];
      3'd3:    ch = hdr[23:16];
      3'd4:    ch = hdr[15:8];
      3'd5:    ch = hdr[7:0];
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/ngrp_in_if.sv
// Byte channel into the NMEA parser: valid/ready plus the received byte.
// Depends on ngrp_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface ngrp_in_if;
  logic                       valid;
  logic                       ready;
  logic [ngrp_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
  modport mon    (input valid, input rx_byte, input ready);
endinterface
`default_nettype wire

// File: hw/rtl/ngrp_out_if.sv
// Record channel out of the NMEA parser: valid/ready plus one line record.
// Depends on ngrp_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface ngrp_out_if;
  logic                        valid;
  logic                        ready;
  logic [ngrp_pkg::KIND_W-1:0] line_kind;
  logic [ngrp_pkg::FIX_W-1:0]  fix_status;
  logic                        fix_changed;
  logic [ngrp_pkg::DATE_W-1:0] date_text;
  logic [ngrp_pkg::TIME_W-1:0] time_text;
  logic [ngrp_pkg::LATW_W-1:0] lat_whole_text;
  logic [ngrp_pkg::LATF_W-1:0] lat_frac_text;
  logic [ngrp_pkg::LONW_W-1:0] lon_whole_text;
  logic [ngrp_pkg::LONF_W-1:0] lon_frac_text;

  modport source (output valid, output line_kind, output fix_status, output fix_changed,
                  output date_text, output time_text, output lat_whole_text,
                  output lat_frac_text, output lon_whole_text, output lon_frac_text,
                  input ready);
  modport sink   (input valid, input line_kind, input fix_status, input fix_changed,
                  input date_text, input time_text, input lat_whole_text,
                  input lat_frac_text, input lon_whole_text, input lon_frac_text,
                  output ready);
  modport mon    (input valid, input line_kind, input fix_status, input fix_changed,
                  input date_text, input time_text, input lat_whole_text,
                  input lat_frac_text, input lon_whole_text, input lon_frac_text,
                  input ready);
endinterface
`default_nettype wire

// File: hw/rtl/nmea_gga_rmc_field_parser.sv
// NMEA 0183 GGA/RMC field parser top level: line assembly, field capture,
// commit of time/date (RMC) or position (GGA with a fix) on each completed line.
// Depends on ngrp_pkg, ngrp_in_if, ngrp_out_if.
//
//   channel | dir | payload                                     | transfer
//   rx      | in  | rx_byte                                     | one serial byte
//   rec     | out | line_kind, fix_status, fix_changed, texts   | one line record
//
// One byte per cycle while rx.ready is high; each byte is fully handled in the cycle it is taken.
// A record appears in the cycle after the newline that ends a non-empty line is taken.
// rx.ready is low only while a record is held and rec.ready is low.
// Synchronous reset clears line state, stored fields and the fix to zero, but sets the header match flags.
`timescale 1ns / 1ps
`default_nettype none
module nmea_gga_rmc_field_parser #(
  parameter int LINE_BUFFER = 128
) (
  input  wire              clk,
  input  wire              rst,
  ngrp_in_if.sink          rx,
  ngrp_out_if.source       rec
);

  localparam int LEN_W = $clog2(LINE_BUFFER);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LINE_BUFFER - 1);

  // line state
  logic [LEN_W-1:0] line_length, line_length_next;
  logic [7:0]       comma_count, comma_count_next;
  logic [3:0]       field_char_pos, field_char_pos_next;
  logic [1:0]       hdr_match, hdr_match_next;
  // shadow captures
  logic [47:0]      sh_time, sh_time_next;
  logic [47:0]      sh_date, sh_date_next;
  logic [63:0]      sh_lat, sh_lat_next;
  logic [39:0]      sh_lon_whole, sh_lon_whole_next;
  logic [31:0]      sh_lon_frac, sh_lon_frac_next;
  logic [7:0]       sh_ns, sh_ns_next;
  logic [7:0]       sh_ew, sh_ew_next;
  logic [ngrp_pkg::PF_W-1:0] sh_present, sh_present_next;
  logic [8:0]       sh_fix_text, sh_fix_text_next;
  // committed values
  logic [47:0]      st_date, st_date_next;
  logic [47:0]      st_time, st_time_next;
  logic [63:0]      st_lat, st_lat_next;
  logic [7:0]       st_lat_ind, st_lat_ind_next;
  logic [39:0]      st_lon_whole, st_lon_whole_next;
  logic [31:0]      st_lon_frac, st_lon_frac_next;
  logic [7:0]       st_lon_ind, st_lon_ind_next;
  logic [1:0]       last_fix, last_fix_next;
  // result register
  logic             rec_valid, rec_valid_next;
  logic [1:0]       rec_kind, rec_kind_next;
  logic             rec_changed, rec_changed_next;

  logic       accept;
  logic [7:0] ch;
  logic       line_end;
  logic [1:0] kind;
  logic [1:0] fix;

  assign accept   = rx.valid && rx.ready;
  assign ch       = rx.rx_byte;
  assign line_end = (ch == ngrp_pkg::NEWLINE) && (line_length != '0);
  assign rx.ready = !rec_valid || rec.ready;

  always_comb begin
    kind = ngrp_pkg::KIND_OTHER;
    if (line_length >= LEN_W'(ngrp_pkg::HDR_LEN)) begin
      if (hdr_match[0]) begin
        kind = ngrp_pkg::KIND_RMC;
      end else if (hdr_match[1]) begin
        kind = ngrp_pkg::KIND_GGA;
      end
    end
    fix = ngrp_pkg::FIX_NONE;
    if (sh_present[ngrp_pkg::PF_FIX] && !sh_fix_text[8]) begin
      if (sh_fix_text[7:0] == ngrp_pkg::CHAR_1) begin
        fix = ngrp_pkg::FIX_GPS;
      end else if (sh_fix_text[7:0] == ngrp_pkg::CHAR_2) begin
        fix = ngrp_pkg::FIX_DGPS;
      end
    end
  end

  always_comb begin
    line_length_next    = line_length;
    comma_count_next    = comma_count;
    field_char_pos_next = field_char_pos;
    hdr_match_next      = hdr_match;
    sh_time_next        = sh_time;
    sh_date_next        = sh_date;
    sh_lat_next         = sh_lat;
    sh_lon_whole_next   = sh_lon_whole;
    sh_lon_frac_next    = sh_lon_frac;
    sh_ns_next          = sh_ns;
    sh_ew_next          = sh_ew;
    sh_present_next     = sh_present;
    sh_fix_text_next    = sh_fix_text;
    st_date_next        = st_date;
    st_time_next        = st_time;
    st_lat_next         = st_lat;
    st_lat_ind_next     = st_lat_ind;
    st_lon_whole_next   = st_lon_whole;
    st_lon_frac_next    = st_lon_frac;
    st_lon_ind_next     = st_lon_ind;
    last_fix_next       = last_fix;
    rec_valid_next      = rec_valid && !rec.ready;
    rec_kind_next       = rec_kind;
    rec_changed_next    = rec_changed;

    if (accept && line_end) begin
      // commit captures (RMC time/date, GGA position with a fix), emit record, start a fresh line
      rec_valid_next   = 1'b1;
      rec_kind_next    = kind;
      rec_changed_next = 1'b0;
      if (kind == ngrp_pkg::KIND_RMC) begin
        if (sh_present[ngrp_pkg::PF_TIME]) st_time_next = sh_time;
        if (sh_present[ngrp_pkg::PF_DATE]) st_date_next = sh_date;
      end else if (kind == ngrp_pkg::KIND_GGA) begin
        rec_changed_next = (fix != last_fix);
        last_fix_next    = fix;
        if (fix != ngrp_pkg::FIX_NONE) begin
          if (sh_present[ngrp_pkg::PF_LAT]) st_lat_next = sh_lat;
          if (sh_present[ngrp_pkg::PF_NS])  st_lat_ind_next = sh_ns;
          if (sh_present[ngrp_pkg::PF_LON]) begin
            st_lon_whole_next = sh_lon_whole;
            st_lon_frac_next  = sh_lon_frac;
          end
          if (sh_present[ngrp_pkg::PF_EW])  st_lon_ind_next = sh_ew;
        end
      end
      line_length_next    = '0;
      comma_count_next    = '0;
      field_char_pos_next = '0;
      hdr_match_next      = 2'b11;
      sh_time_next        = '0;
      sh_date_next        = '0;
      sh_lat_next         = '0;
      sh_lon_whole_next   = '0;
      sh_lon_frac_next    = '0;
      sh_ns_next          = '0;
      sh_ew_next          = '0;
      sh_present_next     = '0;
      sh_fix_text_next    = '0;
    end else if (accept && (line_length < LEN_MAX)) begin
      if (line_length < LEN_W'(ngrp_pkg::HDR_LEN)) begin
        if (ch != ngrp_pkg::hdr_char(ngrp_pkg::HDR_RMC, line_length[2:0])) begin
          hdr_match_next[0] = 1'b0;
        end
        if (ch != ngrp_pkg::hdr_char(ngrp_pkg::HDR_GGA, line_length[2:0])) begin
          hdr_match_next[1] = 1'b0;
        end
      end
      line_length_next = line_length + 1'b1;

      if (ch == ngrp_pkg::COMMA) begin
        // a field counts only when non-empty and closed by a comma
        if (field_char_pos != '0) begin
          case (comma_count)
            ngrp_pkg::FLD_TIME: sh_present_next[ngrp_pkg::PF_TIME] = 1'b1;
            ngrp_pkg::FLD_LAT:  sh_present_next[ngrp_pkg::PF_LAT]  = 1'b1;
            ngrp_pkg::FLD_NS:   sh_present_next[ngrp_pkg::PF_NS]   = 1'b1;
            ngrp_pkg::FLD_LON:  sh_present_next[ngrp_pkg::PF_LON]  = 1'b1;
            ngrp_pkg::FLD_EW:   sh_present_next[ngrp_pkg::PF_EW]   = 1'b1;
            ngrp_pkg::FLD_FIX:  sh_present_next[ngrp_pkg::PF_FIX]  = 1'b1;
            ngrp_pkg::FLD_DATE: sh_present_next[ngrp_pkg::PF_DATE] = 1'b1;
            default: ;
          endcase
        end
        if (comma_count != 8'hFF) comma_count_next = comma_count + 1'b1;
        field_char_pos_next = '0;
      end else begin
        case (comma_count)
          ngrp_pkg::FLD_TIME: begin
            for (int i = 0; i < 6; i++) begin
              if (field_char_pos == 4'(i)) sh_time_next[8*(5-i) +: 8] = ch;
            end
          end
          ngrp_pkg::FLD_DATE: begin
            for (int i = 0; i < 6; i++) begin
              if (field_char_pos == 4'(i)) sh_date_next[8*(5-i) +: 8] = ch;
            end
          end
          ngrp_pkg::FLD_LAT: begin
            // ddmm.ffff: skip the decimal point at position 4
            for (int i = 0; i < 4; i++) begin
              if (field_char_pos == 4'(i)) sh_lat_next[8*(7-i) +: 8] = ch;
            end
            for (int i = 5; i < 9; i++) begin
              if (field_char_pos == 4'(i)) sh_lat_next[8*(8-i) +: 8] = ch;
            end
          end
          ngrp_pkg::FLD_NS: begin
            if (field_char_pos == '0) sh_ns_next = ch;
          end
          ngrp_pkg::FLD_LON: begin
            for (int i = 0; i < 5; i++) begin
              if (field_char_pos == 4'(i)) sh_lon_whole_next[8*(4-i) +: 8] = ch;
            end
            for (int i = 6; i < 10; i++) begin
              if (field_char_pos == 4'(i)) sh_lon_frac_next[8*(9-i) +: 8] = ch;
            end
          end
          ngrp_pkg::FLD_EW: begin
            if (field_char_pos == '0) sh_ew_next = ch;
          end
          ngrp_pkg::FLD_FIX: begin
            // bit 8 marks a fix text longer than one char
            if (field_char_pos == '0) begin
              sh_fix_text_next = {1'b0, ch};
            end else begin
              sh_fix_text_next[8] = 1'b1;
            end
          end
          default: ;
        endcase
        if (field_char_pos != 4'hF) field_char_pos_next = field_char_pos + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length    <= '0;
      comma_count    <= '0;
      field_char_pos <= '0;
      hdr_match      <= 2'b11;
      sh_time        <= '0;
      sh_date        <= '0;
      sh_lat         <= '0;
      sh_lon_whole   <= '0;
      sh_lon_frac    <= '0;
      sh_ns          <= '0;
      sh_ew          <= '0;
      sh_present     <= '0;
      sh_fix_text    <= '0;
      st_date        <= '0;
      st_time        <= '0;
      st_lat         <= '0;
      st_lat_ind     <= '0;
      st_lon_whole   <= '0;
      st_lon_frac    <= '0;
      st_lon_ind     <= '0;
      last_fix       <= ngrp_pkg::FIX_NONE;
      rec_valid      <= 1'b0;
      rec_kind       <= ngrp_pkg::KIND_OTHER;
      rec_changed    <= 1'b0;
    end else begin
      line_length    <= line_length_next;
      comma_count    <= comma_count_next;
      field_char_pos <= field_char_pos_next;
      hdr_match      <= hdr_match_next;
      sh_time        <= sh_time_next;
      sh_date        <= sh_date_next;
      sh_lat         <= sh_lat_next;
      sh_lon_whole   <= sh_lon_whole_next;
      sh_lon_frac    <= sh_lon_frac_next;
      sh_ns          <= sh_ns_next;
      sh_ew          <= sh_ew_next;
      sh_present     <= sh_present_next;
      sh_fix_text    <= sh_fix_text_next;
      st_date        <= st_date_next;
      st_time        <= st_time_next;
      st_lat         <= st_lat_next;
      st_lat_ind     <= st_lat_ind_next;
      st_lon_whole   <= st_lon_whole_next;
      st_lon_frac    <= st_lon_frac_next;
      st_lon_ind     <= st_lon_ind_next;
      last_fix       <= last_fix_next;
      rec_valid      <= rec_valid_next;
      rec_kind       <= rec_kind_next;
      rec_changed    <= rec_changed_next;
    end
  end

  // committed values only change when a new record loads, so they double
  // as the record's text payload
  assign rec.valid          = rec_valid;
  assign rec.line_kind      = rec_kind;
  assign rec.fix_status     = last_fix;
  assign rec.fix_changed    = rec_changed;
  assign rec.date_text      = st_date;
  assign rec.time_text      = st_time;
  assign rec.lat_whole_text = st_lat[63:32];
  assign rec.lat_frac_text  = {st_lat[31:0], st_lat_ind};
  assign rec.lon_whole_text = st_lon_whole;
  assign rec.lon_frac_text  = {st_lon_frac, st_lon_ind};

endmodule
`default_nettype wire

// File: hw/rtl/ngrp_checker.sv
// Port-level assertions for the NMEA parser, bound to the top level.
// Depends on ngrp_pkg, nmea_gga_rmc_field_parser.
`timescale 1ns / 1ps
`default_nettype none
module ngrp_checker (
  input wire                          clk,
  input wire                          rst,
  input wire                          rx_valid,
  input wire                          rx_ready,
  input wire [ngrp_pkg::BYTE_W-1:0]   rx_byte,
  input wire                          rec_valid,
  input wire                          rec_ready,
  input wire [ngrp_pkg::KIND_W-1:0]   rec_line_kind,
  input wire [ngrp_pkg::FIX_W-1:0]    rec_fix_status,
  input wire                          rec_fix_changed,
  input wire [ngrp_pkg::DATE_W-1:0]   rec_date_text,
  input wire [ngrp_pkg::TIME_W-1:0]   rec_time_text,
  input wire [ngrp_pkg::LATW_W-1:0]   rec_lat_whole_text,
  input wire [ngrp_pkg::LATF_W-1:0]   rec_lat_frac_text,
  input wire [ngrp_pkg::LONW_W-1:0]   rec_lon_whole_text,
  input wire [ngrp_pkg::LONF_W-1:0]   rec_lon_frac_text
);

  // a held record keeps its contents until transferred
  a_rec_hold: assert property (@(posedge clk) disable iff (rst)
    rec_valid && !rec_ready |=> rec_valid && $stable(rec_line_kind) &&
      $stable(rec_fix_status) && $stable(rec_fix_changed) && $stable(rec_date_text) &&
      $stable(rec_time_text) && $stable(rec_lat_whole_text) &&
      $stable(rec_lat_frac_text) && $stable(rec_lon_whole_text) &&
      $stable(rec_lon_frac_text))
    else $error("record changed while stalled");

  // a record raised from idle only follows an accepted newline
  a_rec_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(rec_valid) |-> $past(rx_valid && rx_ready && rx_byte == ngrp_pkg::NEWLINE))
    else $error("record without a preceding newline");

  // input is only back-pressured by a waiting record
  a_rx_ready: assert property (@(posedge clk) disable iff (rst)
    !rec_valid |-> rx_ready)
    else $error("input stalled with no record pending");

  // only position lines can report a change of fix
  a_fix_kind: assert property (@(posedge clk) disable iff (rst)
    rec_valid && rec_fix_changed |-> rec_line_kind == ngrp_pkg::KIND_GGA)
    else $error("fix change flagged on a non-GGA line");

endmodule

bind nmea_gga_rmc_field_parser ngrp_checker u_ngrp_checker (
  .clk                (clk),
  .rst                (rst),
  .rx_valid           (rx.valid),
  .rx_ready           (rx.ready),
  .rx_byte            (rx.rx_byte),
  .rec_valid          (rec.valid),
  .rec_ready          (rec.ready),
  .rec_line_kind      (rec.line_kind),
  .rec_fix_status     (rec.fix_status),
  .rec_fix_changed    (rec.fix_changed),
  .rec_date_text      (rec.date_text),
  .rec_time_text      (rec.time_text),
  .rec_lat_whole_text (rec.lat_whole_text),
  .rec_lat_frac_text  (rec.lat_frac_text),
  .rec_lon_whole_text (rec.lon_whole_text),
  .rec_lon_frac_text  (rec.lon_frac_text)
);
`default_nettype wire
